/* rtl/core/cai_pkg.sv */
// Package for the Clifford attractor iterator: types, fixed-point constants,
// register and request codes, and the arctangent table of the CORDIC unit.
// No dependencies.
package cai_pkg;

  localparam int CaiMaxBurstDefault = 64;

  // Angle reduction constants, Q8.24.
  localparam logic signed [31:0] TWO_PI_Q24  = 32'sd105414357;
  localparam logic signed [31:0] PI_Q24      = 32'sd52707179;
  localparam logic signed [31:0] HALF_PI_Q24 = 32'sd26353589;
  localparam logic signed [19:0] CORDIC_GAIN_Q16 = 20'sd39797;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_COEF_A = 3'd0;
  localparam logic [2:0] REG_COEF_B = 3'd1;
  localparam logic [2:0] REG_COEF_C = 3'd2;
  localparam logic [2:0] REG_COEF_D = 3'd3;
  localparam logic [2:0] REG_SEED_X = 3'd4;
  localparam logic [2:0] REG_SEED_Y = 3'd5;

  // Request codes.
  localparam logic REQ_STEP    = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_ANGLE, S_LAUNCH, S_WAIT, S_MULX, S_FINX, S_MULY, S_FINY, S_OUT
  } seq_state_t;

  typedef enum logic [1:0] {C_IDLE, C_REDUCE, C_FOLD, C_ROTATE} cordic_state_t;

  // atan(2^-i) in Q.16.
  function automatic logic [16:0] atan_q16(input logic [3:0] i);
    logic [16:0] v;
    case (i)
      4'd0:    v = 17'd51472;
      4'd1:    v = 17'd30386;
      4'd2:    v = 17'd16055;
      4'd3:    v = 17'd8150;
      4'd4:    v = 17'd4091;
      4'd5:    v = 17'd2047;
      4'd6:    v = 17'd1024;
      4'd7:    v = 17'd512;
      4'd8:    v = 17'd256;
      4'd9:    v = 17'd128;
      4'd10:   v = 17'd64;
      4'd11:   v = 17'd32;
      4'd12:   v = 17'd16;
      4'd13:   v = 17'd8;
      4'd14:   v = 17'd4;
      default: v = 17'd2;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/cai_if.sv */
// Channel interfaces of the Clifford attractor iterator: request and result.
// Depends on nothing.
interface cai_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [6:0] burst_count;
  modport source (output valid, req_type, burst_count, input ready);
  modport sink (input valid, req_type, burst_count, output ready);
endinterface

interface cai_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] x_out;
  logic [15:0] y_out;
  logic [5:0]  burst_index;
  logic [31:0] iteration_count;
  logic        last;
  modport source (output valid, x_out, y_out, burst_index, iteration_count, last,
                  input ready);
  modport sink (input valid, x_out, y_out, burst_index, iteration_count, last,
                output ready);
endinterface

/* rtl/core/cai_cordic.sv */
// Iterative sine/cosine unit: reduces a Q8.24 angle modulo 2*pi one
// conditional subtract a cycle, folds it to +-pi/2, then runs 16 CORDIC steps.
// Depends on cai_pkg.
module cai_cordic import cai_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               done,
  output logic signed [19:0] sin_q16,
  output logic signed [19:0] cos_q16
);

  cordic_state_t state, state_next;
  logic signed [31:0] r;
  logic [2:0]  k;
  logic [3:0]  i;
  logic signed [19:0] cx, cy, z;
  logic flip;

  logic signed [31:0] red_const, r_wrap, r_fold;
  logic flip_next;
  logic signed [19:0] sx, sy, at, cx_n, cy_n, z_n;

  always_comb begin
    state_next = state;
    case (state)
      C_IDLE:   if (start) state_next = C_REDUCE;
      C_REDUCE: if (k == 3'd0) state_next = C_FOLD;
      C_FOLD:   state_next = C_ROTATE;
      C_ROTATE: if (i == 4'd15) state_next = C_IDLE;
      default:  state_next = C_IDLE;
    endcase
  end

  always_comb begin
    red_const = TWO_PI_Q24 <<< k;
    r_wrap = (r > PI_Q24) ? r - TWO_PI_Q24 : r;
    flip_next = 1'b0;
    r_fold = r_wrap;
    if (r_wrap > HALF_PI_Q24) begin
      r_fold = r_wrap - PI_Q24;
      flip_next = 1'b1;
    end else if (r_wrap < -HALF_PI_Q24) begin
      r_fold = r_wrap + PI_Q24;
      flip_next = 1'b1;
    end
    sx = cx >>> i;
    sy = cy >>> i;
    at = signed'({3'b000, atan_q16(i)});
    if (!z[19]) begin
      cx_n = cx - sy;
      cy_n = cy + sx;
      z_n = z - at;
    end else begin
      cx_n = cx + sy;
      cy_n = cy - sx;
      z_n = z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == C_ROTATE) && (i == 4'd15);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        // Lift negative products into range; 16 periods cover the full span.
        r <= angle[31] ? angle + (TWO_PI_Q24 <<< 4) : angle;
        k <= 3'd4;
      end
      C_REDUCE: begin
        if (r >= red_const) r <= r - red_const;
        k <= k - 3'd1;
      end
      C_FOLD: begin
        z    <= 20'(r_fold >>> 8);
        flip <= flip_next;
        cx   <= CORDIC_GAIN_Q16;
        cy   <= '0;
        i    <= '0;
      end
      C_ROTATE: begin
        cx <= cx_n;
        cy <= cy_n;
        z  <= z_n;
        i  <= i + 4'd1;
        if (i == 4'd15) begin
          sin_q16 <= flip ? -cy_n : cy_n;
          cos_q16 <= flip ? -cx_n : cx_n;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/clifford_attractor_iterator_unit.sv */
// Top level of the Clifford attractor iterator: configuration registers,
// iteration sequencer and shared multiplier. Depends on cai_pkg, cai_if, cai_cordic.
//
//   channel  | direction | handshake          | payload
//   req      | in        | valid/ready        | req_type, burst_count
//   res      | out       | valid/ready        | x_out, y_out, burst_index,
//            |           |                    | iteration_count, last
//   config   | in        | APB write/read     | coef_a..seed_y at 4*i
//
// Each iteration runs four sine or cosine evaluations (one angle product, one
// launch and a wait on the shared CORDIC unit each), then two coefficient
// products and two rounding steps, then shows the result, holding it while the
// sink holds ready low. A restart transaction is taken in the idle state and
// leaves the sequencer there.
// Reset is synchronous and restores the registers and the point to defaults.
// The request side is ready only while no burst is running.
module clifford_attractor_iterator_unit import cai_pkg::*; #(
  parameter int MAX_BURST = CaiMaxBurstDefault
) (
  input  logic        clk,
  input  logic        rst,
  cai_req_if.sink     req,
  cai_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [6:0] BurstCap = 7'(MAX_BURST);

  // Configuration registers.
  logic signed [15:0] coef_a, coef_b, coef_c, coef_d, seed_x, seed_y;
  logic [2:0] reg_index;
  logic       cfg_write;

  // Iteration state.
  logic signed [15:0] x_coord, y_coord, x_new;
  logic [31:0] total_count;
  logic [6:0]  n_burst, n_cap;
  logic [5:0]  idx;
  logic [1:0]  eval;

  seq_state_t state, state_next;

  // Shared multiplier and its operands.
  logic signed [15:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [35:0] prod;
  logic signed [19:0] s_x, c_x, s_y, c_y, s_sel;

  // CORDIC unit hookup.
  logic cordic_start, cordic_done;
  logic signed [19:0] cordic_sin, cordic_cos;

  // Rounding and saturation of sin + coef*cos.
  logic signed [25:0] v_sum;
  logic signed [21:0] q_round;
  logic signed [15:0] q_sat;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (reg_index)
      REG_COEF_A: prdata = 32'(coef_a);
      REG_COEF_B: prdata = 32'(coef_b);
      REG_COEF_C: prdata = 32'(coef_c);
      REG_COEF_D: prdata = 32'(coef_d);
      REG_SEED_X: prdata = 32'(seed_x);
      REG_SEED_Y: prdata = 32'(seed_y);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= -16'sd5734;
      coef_b <= 16'sd6554;
      coef_c <= 16'sd4096;
      coef_d <= 16'sd2867;
      seed_x <= 16'sd410;
      seed_y <= 16'sd0;
    end else if (cfg_write) begin
      case (reg_index)
        REG_COEF_A: coef_a <= pwdata[15:0];
        REG_COEF_B: coef_b <= pwdata[15:0];
        REG_COEF_C: coef_c <= pwdata[15:0];
        REG_COEF_D: coef_d <= pwdata[15:0];
        REG_SEED_X: seed_x <= pwdata[15:0];
        REG_SEED_Y: seed_y <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Bursts longer than the parameter are cut to it.
  assign n_cap = (req.burst_count > BurstCap) ? BurstCap : req.burst_count;

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:
        if (req.valid && req.req_type == REQ_STEP && n_cap != 7'd0) state_next = S_ANGLE;
      S_ANGLE:  state_next = S_LAUNCH;
      S_LAUNCH: state_next = S_WAIT;
      S_WAIT:
        if (cordic_done) state_next = (eval == 2'd3) ? S_MULX : S_ANGLE;
      S_MULX: state_next = S_FINX;
      S_FINX: state_next = S_MULY;
      S_MULY: state_next = S_FINY;
      S_FINY: state_next = S_OUT;
      S_OUT:
        if (res.ready) state_next = res.last ? S_IDLE : S_ANGLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs and multiplier operand selection.
  always_comb begin
    req.ready    = (state == S_IDLE);
    res.valid    = (state == S_OUT);
    cordic_start = (state == S_LAUNCH);
    mul_a = coef_a;
    mul_b = 20'(y_coord);
    s_sel = s_x;
    case (state)
      S_ANGLE: begin
        case (eval)
          2'd0:    begin mul_a = coef_a; mul_b = 20'(y_coord); end
          2'd1:    begin mul_a = coef_a; mul_b = 20'(x_coord); end
          2'd2:    begin mul_a = coef_b; mul_b = 20'(x_coord); end
          default: begin mul_a = coef_b; mul_b = 20'(y_coord); end
        endcase
      end
      S_MULX: begin mul_a = coef_c; mul_b = c_x; end
      S_MULY: begin mul_a = coef_d; mul_b = c_y; end
      S_FINY: s_sel = s_y;
      default: ;
    endcase
  end

  always_comb begin
    v_sum   = 26'(s_sel) + 26'(prod >>> 12);
    q_round = 22'((v_sum + 26'sd8) >>> 4);
    if (q_round > 22'sd32767)       q_sat = 16'sd32767;
    else if (q_round < -22'sd32768) q_sat = -16'sd32768;
    else                            q_sat = q_round[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_coord     <= 16'sd410;
      y_coord     <= 16'sd0;
      total_count <= '0;
      eval        <= '0;
      idx         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid && req.req_type == REQ_RESTART) begin
            x_coord     <= seed_x;
            y_coord     <= seed_y;
            total_count <= '0;
          end
          n_burst <= n_cap;
          idx     <= '0;
          eval    <= '0;
        end
        S_WAIT: begin
          if (cordic_done) begin
            case (eval)
              2'd0:    s_x <= cordic_sin;
              2'd1:    c_x <= cordic_cos;
              2'd2:    s_y <= cordic_sin;
              default: c_y <= cordic_cos;
            endcase
            eval <= eval + 2'd1;
          end
        end
        S_FINX: x_new <= q_sat;
        S_FINY: begin
          // Both coordinates change together so y uses the old x above.
          x_coord             <= x_new;
          y_coord             <= q_sat;
          total_count         <= total_count + 32'd1;
          res.x_out           <= x_new;
          res.y_out           <= q_sat;
          res.iteration_count <= total_count + 32'd1;
          res.burst_index     <= idx;
          res.last            <= ({1'b0, idx} + 7'd1) == n_burst;
        end
        S_OUT: if (res.ready) idx <= idx + 6'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ANGLE || state == S_MULX || state == S_MULY) prod <= mul_a * mul_b;
  end

  cai_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .angle   (prod[31:0]),
    .done    (cordic_done),
    .sin_q16 (cordic_sin),
    .cos_q16 (cordic_cos)
  );

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.req_type == REQ_RESTART |=> total_count == 32'd0)
    else $error("restart did not clear the iteration count");

  a_last_frees_req: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready && res.last |=> req.ready)
    else $error("request side not ready after the final result");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && res.valid))
    else $error("request accepted while a result is pending");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready |-> res.iteration_count == total_count)
    else $error("result count differs from the running count");

endmodule

/* tb/tb_clifford_attractor_iterator_unit.sv */
// Self-checking testbench for clifford_attractor_iterator_unit: directed and random
// requests, random idling on both channels, and an in-house fixed-point predictor.
// Depends on cai_pkg, cai_if and the RTL of the block.
module tb_clifford_attractor_iterator_unit;
  import cai_pkg::*;

  localparam int          MAX_BURST  = 64;
  localparam int          RAND_ITEMS = 380;
  localparam int          PHASES     = 4;
  localparam int          WD_LIMIT   = 6000;
  // Past the last expected point, a restart may still be finishing; this
  // margin covers it.
  localparam int          SETTLE     = 150;
  localparam logic [2:0]  REG_SPARE  = 3'd6;  // not a register: writes are ignored

  localparam longint TWO_PI  = 105414357;
  localparam longint PI_Q    = 52707179;
  localparam longint HALF_PI = 26353589;
  localparam longint GAIN    = 39797;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cai_req_if req ();
  cai_res_if res ();

  clifford_attractor_iterator_unit #(.MAX_BURST(MAX_BURST)) u_top (
    .clk(clk), .rst(rst), .req(req.sink), .res(res.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [5:0]  idx;
    logic [31:0] cnt;
    logic        last;
  } point_t;

  // Shadow copy of the registers and of the point held by the block.
  logic [15:0] m_coef [6];
  logic [15:0] m_x, m_y;
  logic [31:0] m_count;
  point_t      points_due [$];

  int  errors = 0;
  bit  quiet = 0;      // a stretch with no idling on either side
  bit  typed_due = 0;  // first point of the next request has a known count
  logic [31:0] typed_cnt;
  int  idle_cycles = 0;

  initial begin
    req.valid = 1'b0;
    req.req_type = REQ_STEP;
    req.burst_count = '0;
    res.ready = 1'b0;
  end

  // Sine and cosine of a Q8.24 angle, in Q.16, by the block's 16-step CORDIC.
  function automatic void cordic_sin_cos(input longint p, output longint s,
                                         output longint c);
    longint r, cx, cy, z, nx, ny;
    bit flip;
    longint atan_tab [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                              256, 128, 64, 32, 16, 8, 4, 2};
    r = p % TWO_PI;
    if (r < 0) r += TWO_PI;
    if (r > PI_Q) r -= TWO_PI;
    flip = 0;
    if (r > HALF_PI) begin
      r -= PI_Q;
      flip = 1;
    end else if (r < -HALF_PI) begin
      r += PI_Q;
      flip = 1;
    end
    z = r >>> 8;
    cx = GAIN;
    cy = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = cx - (cy >>> i);
        ny = cy + (cx >>> i);
        z -= atan_tab[i];
      end else begin
        nx = cx + (cy >>> i);
        ny = cy - (cx >>> i);
        z += atan_tab[i];
      end
      cx = nx;
      cy = ny;
    end
    s = flip ? -cy : cy;
    c = flip ? -cx : cx;
  endfunction

  // sin(k*u) + m*cos(k*w), rounded half up to Q4.12 and saturated.
  function automatic logic [15:0] attractor_term(input logic signed [15:0] k,
      input logic signed [15:0] u, input logic signed [15:0] w,
      input logic signed [15:0] m);
    longint s, c, dummy, v, q;
    cordic_sin_cos(longint'(k) * longint'(u), s, dummy);
    cordic_sin_cos(longint'(k) * longint'(w), dummy, c);
    v = s + ((longint'(m) * c) >>> 12);
    q = (v + 8) >>> 4;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // Works out the points that one accepted request produces.
  task automatic predict_points(input logic rt, input logic [6:0] bc);
    int n;
    point_t p;
    logic [15:0] nx, ny;
    if (rt == REQ_RESTART) begin
      m_x = m_coef[REG_SEED_X];
      m_y = m_coef[REG_SEED_Y];
      m_count = '0;
    end else begin
      n = (bc > MAX_BURST) ? MAX_BURST : bc;
      for (int f = 0; f < n; f++) begin
        nx = attractor_term(m_coef[REG_COEF_A], m_y, m_x, m_coef[REG_COEF_C]);
        ny = attractor_term(m_coef[REG_COEF_B], m_x, m_y, m_coef[REG_COEF_D]);
        m_x = nx;
        m_y = ny;
        m_count = m_count + 1;
        p = '{x: nx, y: ny, idx: f[5:0], cnt: m_count, last: (f + 1 == n)};
        if (f == 0 && typed_due && p.cnt !== typed_cnt) begin
          $display("%0t: count of first point: expected %0d, actual %0d",
                   $time, typed_cnt, p.cnt);
          errors++;
        end
        points_due.push_back(p);
      end
    end
  endtask

  // Transactions are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    point_t e;
    bit moved;
    if (!rst) begin
      moved = psel;
      if (req.valid && req.ready) begin
        predict_points(req.req_type, req.burst_count);
        moved = 1;
      end
      if (res.valid && res.ready) begin
        moved = 1;
        if (points_due.size() == 0) begin
          $display("%0t: unexpected point: expected none, actual x=%h y=%h",
                   $time, res.x_out, res.y_out);
          errors++;
        end else begin
          e = points_due.pop_front();
          if (res.x_out !== e.x || res.y_out !== e.y || res.burst_index !== e.idx ||
              res.iteration_count !== e.cnt || res.last !== e.last) begin
            $display("%0t: point mismatch: expected x=%h y=%h idx=%0d cnt=%0d last=%b",
                     $time, e.x, e.y, e.idx, e.cnt, e.last);
            $display("%0t:                 actual   x=%h y=%h idx=%0d cnt=%0d last=%b",
                     $time, res.x_out, res.y_out, res.burst_index,
                     res.iteration_count, res.last);
            errors++;
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // The result side stalls with a chance of about 23 in a hundred, except in the quiet stretch.
  always @(negedge clk)
    res.ready <= quiet || ($urandom_range(99) >= 23);

  // Sends one request. Gaps are inserted before raising valid; valid stays high
  // between back-to-back requests so it is never lowered and raised in one step.
  task automatic send_request(input logic rt, input logic [6:0] bc);
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 23) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= rt;
    req.burst_count <= bc;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {$urandom_range(65535), val};  // upper half carries random junk
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx <= REG_SEED_Y) m_coef[idx] = val;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Lets all expected points drain, then waits out a possible trailing restart.
  task automatic drain();
    @(negedge clk);
    req.valid <= 1'b0;
    while (points_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  typedef struct {
    logic        rt;
    logic [6:0]  bc;
    bit          known;
    logic [31:0] cnt;
  } directed_row_t;

  // Counts after a restart are known at a glance; the points come from the predictor.
  directed_row_t directed [] = '{
    '{REQ_RESTART, 7'd0,   0, 0},
    '{REQ_STEP,    7'd1,   1, 1},
    '{REQ_STEP,    7'd0,   0, 0},   // zero burst leaves the point alone
    '{REQ_STEP,    7'd3,   1, 2},
    '{REQ_RESTART, 7'd127, 0, 0},   // burst field is ignored on restart
    '{REQ_STEP,    7'd1,   1, 1},
    '{REQ_STEP,    7'd64,  1, 2},   // largest burst
    '{REQ_STEP,    7'd65,  1, 66},  // cut down to the largest burst
    '{REQ_STEP,    7'd127, 1, 130},
    '{REQ_RESTART, 7'd42,  0, 0},
    '{REQ_STEP,    7'd2,   1, 1},
    '{REQ_STEP,    7'd0,   0, 0}
  };

  initial begin
    logic [6:0] bc;
    int pick;
    m_coef = '{16'(-5734), 16'd6554, 16'd4096, 16'd2867, 16'd410, 16'd0};
    m_x = 16'd410;
    m_y = 16'd0;
    m_count = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part on the reset values of the registers. The typed count is
    // changed only at a falling edge, away from the edge where it is read.
    foreach (directed[i]) begin
      @(negedge clk);
      typed_due = directed[i].known;
      typed_cnt = directed[i].cnt;
      send_request(directed[i].rt, directed[i].bc);
    end
    @(negedge clk);
    typed_due = 0;
    drain();

    // Random part in phases, each on a new register setting. The second phase
    // puts every register at its most negative value, the third at its most
    // positive one; the others are random.
    for (int ph = 0; ph < PHASES; ph++) begin
      for (int r = 0; r <= REG_SEED_Y; r++) begin
        case (ph)
          1:       apb_write(r[2:0], 16'h8000);
          2:       apb_write(r[2:0], 16'h7fff);
          default: apb_write(r[2:0], 16'($urandom));
        endcase
      end
      apb_write(REG_SPARE, 16'($urandom));
      send_request(REQ_RESTART, 7'($urandom));
      for (int k = 0; k < RAND_ITEMS / PHASES; k++) begin
        quiet = (ph == 0 && k >= 40 && k < 75);
        pick = $urandom_range(99);
        if (pick < 70)      bc = 7'($urandom_range(1, 3));
        else if (pick < 88) bc = 7'($urandom_range(0, 8));
        else if (pick < 97) bc = 7'($urandom_range(9, 63));
        else                bc = 7'($urandom_range(64, 127));
        if ($urandom_range(99) < 10) send_request(REQ_RESTART, 7'($urandom));
        else                         send_request(REQ_STEP, bc);
      end
      quiet = 0;
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* clifford_attractor_iterator_unit.f */
rtl/core/cai_pkg.sv
rtl/core/cai_if.sv
rtl/core/cai_cordic.sv
rtl/core/clifford_attractor_iterator_unit.sv
tb/tb_clifford_attractor_iterator_unit.sv
